[rtl/calibration_table_interpolator_macros.svh]
// Assertion helpers for the calibration table interpolator.
// Each check is sampled on clk and disabled while rst is high.
`ifndef CALIBRATION_TABLE_INTERPOLATOR_MACROS_SVH
`define CALIBRATION_TABLE_INTERPOLATOR_MACROS_SVH

// Condition pre implies condition post in the same cycle.
`define CTI_ASSERT_SAME(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("calibration_table_interpolator: same-cycle check failed");

// Condition pre implies condition post in the next cycle.
`define CTI_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("calibration_table_interpolator: next-cycle check failed");

`endif

[rtl/clti_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package clti_pkg;

  localparam int MAX_POINTS  = 32;
  localparam int PGA_STEPS   = 8;
  localparam int RANGE_STEPS = 4;
  localparam int NCOEF       = 2 * PGA_STEPS + RANGE_STEPS + 2;

  localparam int PT_W    = 5;
  localparam int CNT_W   = 6;
  localparam int COEF_W  = 5;
  localparam int ADDR_W  = 10;
  localparam int FREQ_W  = 24;
  localparam int VAL_W   = 48;
  localparam int WGT_W   = 17;
  localparam int DIV_W   = FREQ_W + 17;
  localparam int WONE    = 65536;

  // Commands.
  localparam logic [1:0] CMD_FREQ   = 2'd0;
  localparam logic [1:0] CMD_COEF   = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_EXACT      = 3'd0;
  localparam logic [2:0] ST_CLAMP_LOW  = 3'd1;
  localparam logic [2:0] ST_CLAMP_HIGH = 3'd2;
  localparam logic [2:0] ST_INTERP     = 3'd3;
  localparam logic [2:0] ST_EMPTY      = 3'd4;

  // One coefficient: real part in the upper half, imaginary in the lower.
  typedef struct packed {
    logic signed [VAL_W-1:0] re;
    logic signed [VAL_W-1:0] im;
  } cplx_t;

endpackage
`default_nettype wire

[rtl/clti_store.sv]
`timescale 1ns / 1ps
`default_nettype none
module clti_store import clti_pkg::*; (
  input  wire logic              clk,
  input  wire logic              freq_we,
  input  wire logic [PT_W-1:0]   freq_waddr,
  input  wire logic [FREQ_W-1:0] freq_wdata,
  input  wire logic [PT_W-1:0]   freq_raddr,
  output logic      [FREQ_W-1:0] freq_rdata,
  input  wire logic              coeff_we,
  input  wire logic [ADDR_W-1:0] coeff_waddr,
  input  wire cplx_t             coeff_wdata,
  input  wire logic [ADDR_W-1:0] coeff_raddr_a,
  input  wire logic [ADDR_W-1:0] coeff_raddr_b,
  output cplx_t                  coeff_rdata_a,
  output cplx_t                  coeff_rdata_b
);

  logic [FREQ_W-1:0] freq_mem [MAX_POINTS];
  cplx_t             coeff_mem [MAX_POINTS*NCOEF];

  // Point frequency memory, one write and one registered read.
  always_ff @(posedge clk) begin
    if (freq_we) begin
      freq_mem[freq_waddr] <= freq_wdata;
    end
    freq_rdata <= freq_mem[freq_raddr];
  end

  // Coefficient memory, one write and two registered reads.
  always_ff @(posedge clk) begin
    if (coeff_we) begin
      coeff_mem[coeff_waddr] <= coeff_wdata;
    end
    coeff_rdata_a <= coeff_mem[coeff_raddr_a];
    coeff_rdata_b <= coeff_mem[coeff_raddr_b];
  end

endmodule
`default_nettype wire

[rtl/clti_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module clti_div import clti_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [FREQ_W-1:0] divisor,
  output logic                   busy,
  output logic                   done,
  output logic      [DIV_W-1:0]  quotient
);

  logic [CNT_W-1:0]  count;
  logic [FREQ_W:0]   rem;
  logic [FREQ_W-1:0] dvs;
  logic [FREQ_W:0]   rem_sh;
  logic [FREQ_W+1:0] trial;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign rem_sh = {rem[FREQ_W-1:0], quotient[DIV_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIV_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient register doubles as the dividend shifter.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (!trial[FREQ_W+1]) begin
        rem      <= trial[FREQ_W:0];
        quotient <= {quotient[DIV_W-2:0], 1'b1};
      end else begin
        rem      <= rem_sh;
        quotient <= {quotient[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

[rtl/clti_blend.sv]
`timescale 1ns / 1ps
`default_nettype none
module clti_blend import clti_pkg::*; (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire cplx_t            c_lo,
  input  wire cplx_t            c_hi,
  input  wire logic [WGT_W-1:0] w_lo,
  input  wire logic [WGT_W-1:0] w_hi,
  output cplx_t                 result
);

  localparam int PW = VAL_W + WGT_W + 1;

  logic signed [PW-1:0] p_lo_re, p_hi_re, p_lo_im, p_hi_im;
  logic signed [PW:0]   s_re, s_im;

  // Weighted products, registered before the sum.
  always_ff @(posedge clk) begin
    if (load) begin
      p_lo_re <= c_lo.re * $signed({1'b0, w_lo});
      p_hi_re <= c_hi.re * $signed({1'b0, w_hi});
      p_lo_im <= c_lo.im * $signed({1'b0, w_lo});
      p_hi_im <= c_hi.im * $signed({1'b0, w_hi});
    end
  end

  // Sum, round half up, and take the Q32.16 bits.
  assign s_re = {p_lo_re[PW-1], p_lo_re} + {p_hi_re[PW-1], p_hi_re} + (PW+1)'(32768);
  assign s_im = {p_lo_im[PW-1], p_lo_im} + {p_hi_im[PW-1], p_hi_im} + (PW+1)'(32768);

  assign result.re = s_re[VAL_W+15:16];
  assign result.im = s_im[VAL_W+15:16];

endmodule
`default_nettype wire

[rtl/calibration_table_interpolator.sv]
// Calibration table interpolator.
// Input channel (in_valid/in_ready) carries one request: a point frequency
// write, a coefficient write, or a lookup. Writes complete in the cycle they
// are accepted and produce no result. A lookup produces 22 results on the
// output channel (out_valid/out_ready), coefficient 0 first, last set on the
// final one; with point_count 0 it produces a single empty-status result.
// A lookup first scans up to n points from the frequency memory (one point per
// cycle through its registered read port), then, when interpolating, runs the
// bit-serial weight divider (one quotient bit per cycle), then passes each
// coefficient through the coefficient memory read and the registered
// multiply. Requests are taken one at a time; in_ready is high only while idle.
// A stalled receiver holds the output register; the block waits with it.
// point_count (cfg_we/cfg_data) may be written at any time while idle.
// Reset clears point_count and the control state; table memories are not
// cleared and must be written before use.
`timescale 1ns / 1ps
`default_nettype none
`include "calibration_table_interpolator_macros.svh"
module calibration_table_interpolator import clti_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CNT_W-1:0]        cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              cmd,
  input  wire logic [PT_W-1:0]         point_index,
  input  wire logic [COEF_W-1:0]       coeff_index,
  input  wire logic [FREQ_W-1:0]       frequency,
  input  wire logic signed [VAL_W-1:0] value_re,
  input  wire logic signed [VAL_W-1:0] value_im,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [COEF_W-1:0]            out_index,
  output logic signed [VAL_W-1:0]      out_re,
  output logic signed [VAL_W-1:0]      out_im,
  output logic [2:0]                   status,
  output logic                         last
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_DIV    = 8'b0000_1000,
    S_RD     = 8'b0001_0000,
    S_MUL    = 8'b0010_0000,
    S_SUM    = 8'b0100_0000,
    S_EMPTY  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]  point_count;
  logic [CNT_W-1:0]  n_pts;
  logic [FREQ_W-1:0] freq_req;
  logic [CNT_W-1:0]  scan_i;
  logic              cmp_valid;
  logic [PT_W-1:0]   cmp_i;
  logic              found;
  logic [PT_W-1:0]   sel;
  logic [PT_W-1:0]   lo;
  logic [FREQ_W-1:0] flo;
  logic [FREQ_W-1:0] fhi;
  logic              lt0;
  logic [2:0]        res_status;
  logic [ADDR_W-1:0] base_lo;
  logic [ADDR_W-1:0] base_hi;
  logic [WGT_W-1:0]  w_hi;
  logic [COEF_W-1:0] emit_k;

  logic              accept;
  logic              issue;
  logic              out_free;
  logic              out_load;
  logic              pf_exact;
  logic [FREQ_W:0]   diff;
  logic [FREQ_W:0]   dfreq;
  logic [FREQ_W-1:0] pf;

  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [DIV_W-1:0]  div_quot;
  logic [DIV_W-1:0]  div_dividend;

  logic [FREQ_W-1:0] freq_rdata;
  cplx_t             rd_a, rd_b, blend_out;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign n_pts    = (point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count;
  assign out_free = !out_valid || out_ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_we) begin
      point_count <= cfg_data;
    end
  end

  // Table memories.
  clti_store u_store (
    .clk           (clk),
    .freq_we       (accept && cmd == CMD_FREQ),
    .freq_waddr    (point_index),
    .freq_wdata    (frequency),
    .freq_raddr    (scan_i[PT_W-1:0]),
    .freq_rdata    (freq_rdata),
    .coeff_we      (accept && cmd == CMD_COEF && coeff_index < COEF_W'(NCOEF)),
    .coeff_waddr   (ADDR_W'(point_index) * ADDR_W'(NCOEF) + ADDR_W'(coeff_index)),
    .coeff_wdata   ('{re: value_re, im: value_im}),
    .coeff_raddr_a (base_lo + ADDR_W'(emit_k)),
    .coeff_raddr_b (base_hi + ADDR_W'(emit_k)),
    .coeff_rdata_a (rd_a),
    .coeff_rdata_b (rd_b)
  );

  // Scan compare on the point read in the previous cycle.
  assign pf       = freq_rdata;
  assign diff     = {1'b0, freq_req} - {1'b0, pf};
  assign pf_exact = (diff == '0) || (diff == (FREQ_W+1)'(1)) || (diff == '1);
  assign issue    = (state == S_SCAN) && (scan_i < n_pts) && !found;

  // Interpolation weight divider: round(num * 2^16 / d).
  assign dfreq        = {1'b0, fhi} - {1'b0, flo};
  assign div_dividend = DIV_W'({freq_req - flo, 16'h0000}) + DIV_W'(dfreq[FREQ_W:1]);
  assign div_start    = (state == S_DECIDE) && !found && !(lo == '0 && lt0) &&
                        ({1'b0, lo} != n_pts - 1'b1) && !dfreq[FREQ_W] && (dfreq != '0);

  clti_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (dfreq[FREQ_W-1:0]),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Coefficient blend.
  clti_blend u_blend (
    .clk    (clk),
    .load   (state == S_MUL),
    .c_lo   (rd_a),
    .c_hi   (rd_b),
    .w_lo   (WGT_W'(WONE) - w_hi),
    .w_hi   (w_hi),
    .result (blend_out)
  );

  assign out_load = ((state == S_SUM) || (state == S_EMPTY)) && out_free;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cmp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && cmd == CMD_LOOKUP) begin
            state <= (n_pts == '0) ? S_EMPTY : S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_valid <= issue;
          if (!issue && !cmp_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= div_start ? S_DIV : S_RD;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_SUM;
        end
        S_SUM: begin
          if (out_free) begin
            state <= (emit_k == COEF_W'(NCOEF - 1)) ? S_IDLE : S_RD;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Scan and lookup datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      freq_req <= frequency;
      scan_i   <= '0;
      found    <= 1'b0;
      lo       <= '0;
      lt0      <= 1'b0;
      emit_k   <= '0;
    end
    if (issue) begin
      scan_i <= scan_i + 1'b1;
      cmp_i  <= scan_i[PT_W-1:0];
    end
    if (state == S_SCAN && cmp_valid && !found) begin
      if (pf_exact) begin
        found <= 1'b1;
        sel   <= cmp_i;
      end else begin
        if (pf < freq_req) begin
          lo  <= cmp_i;
          flo <= pf;
        end
        if ({1'b0, cmp_i} == {1'b0, lo} + 1'b1) begin
          fhi <= pf;
        end
        if (cmp_i == '0) begin
          lt0 <= (freq_req < pf);
        end
      end
    end
    if (state == S_DECIDE) begin
      w_hi <= '0;
      if (found) begin
        res_status <= ST_EXACT;
        base_lo    <= ADDR_W'(sel) * ADDR_W'(NCOEF);
        base_hi    <= ADDR_W'(sel) * ADDR_W'(NCOEF);
      end else if (lo == '0 && lt0) begin
        res_status <= ST_CLAMP_LOW;
        base_lo    <= '0;
        base_hi    <= '0;
      end else if ({1'b0, lo} == n_pts - 1'b1) begin
        res_status <= ST_CLAMP_HIGH;
        base_lo    <= ADDR_W'(lo) * ADDR_W'(NCOEF);
        base_hi    <= ADDR_W'(lo) * ADDR_W'(NCOEF);
      end else begin
        res_status <= ST_INTERP;
        base_lo    <= ADDR_W'(lo) * ADDR_W'(NCOEF);
        base_hi    <= ADDR_W'(lo) * ADDR_W'(NCOEF) + ADDR_W'(NCOEF);
      end
    end
    if (state == S_DIV && div_done) begin
      w_hi <= (div_quot > DIV_W'(WONE)) ? WGT_W'(WONE) : div_quot[WGT_W-1:0];
    end
    if (state == S_SUM && out_free) begin
      emit_k <= emit_k + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_EMPTY) begin
        out_index <= '0;
        out_re    <= '0;
        out_im    <= '0;
        status    <= ST_EMPTY;
        last      <= 1'b1;
      end else begin
        out_index <= emit_k;
        out_re    <= blend_out.re;
        out_im    <= blend_out.im;
        status    <= res_status;
        last      <= (emit_k == COEF_W'(NCOEF - 1));
      end
    end
  end

  // An empty-table result is always the final result of its lookup.
  `CTI_ASSERT_SAME(a_empty_last, out_valid && status == ST_EMPTY, last)
  // The divider only runs while the sequencer waits for it.
  `CTI_ASSERT_SAME(a_div_owned, div_busy, state == S_DIV)
  // The coefficient counter never runs past the last coefficient.
  `CTI_ASSERT_SAME(a_k_range, state != S_IDLE, emit_k <= COEF_W'(NCOEF - 1))
  // A loaded result is held until the receiver takes it.
  `CTI_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)

endmodule
`default_nettype wire
